### design/cbc_pkg.sv
// Shared types, pipeline stage map and saturation helper for the
// circle boundary clearance block. No dependencies.
`default_nettype none
package cbc_pkg;

    localparam int NSQ     = 33;              // root bits, two radicand bits per stage
    localparam int NDIV    = 31;              // quotient bits, one per stage
    localparam int ST_DIFF = 0;
    localparam int ST_MAG  = 1;
    localparam int ST_SQR  = 2;
    localparam int ST_SUM  = 3;
    localparam int ST_SQ0  = 4;
    localparam int ST_MUL  = ST_SQ0 + NSQ;
    localparam int ST_NUM  = ST_MUL + 1;
    localparam int ST_DV0  = ST_NUM + 1;
    localparam int NSTG    = ST_DV0 + NDIV;

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_RADIUS   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } in_t;

    typedef struct packed {
        logic               inside_res;
        logic signed [31:0] clearance;
        logic signed [31:0] near_x;
        logic signed [31:0] near_y;
        logic signed [31:0] near_z;
        logic               degenerate;
    } out_t;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [32:0]        ux;
        logic [32:0]        uy;
        logic               sx;
        logic               sy;
        logic [65:0]        sqx;
        logic [65:0]        sqy;
        logic [65:0]        val;
        logic [35:0]        rem;
        logic [32:0]        root;
        logic [63:0]        prx;
        logic [63:0]        pry;
        logic [65:0]        numx;
        logic [65:0]        numy;
        logic [33:0]        den;
        logic [30:0]        qx;
        logic [30:0]        qy;
        logic signed [31:0] z;
    } pipe_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### design/circle_boundary_clearance.sv
// Top level of the circle boundary clearance block: config registers,
// the full arithmetic pipeline and the output register. Uses cbc_pkg.
//
// One query point enters per cycle while the pipe can move, and its result
// leaves through difference, magnitude, squares, sum, 33 square-root stages of
// two radicand bits each, scale multiply, numerator, 31 restoring-divide stages
// and the output register. Throughput is one request per cycle; each stage
// takes a new request whenever it or any stage after it is empty, so a
// stalled result only stops the pipe once every stage holds a request.
// Config writes are meant for an idle block.
`default_nettype none
module circle_boundary_clearance (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  cbc_pkg::in_t  s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output cbc_pkg::out_t m_data,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    import cbc_pkg::*;

    logic signed [31:0] cx_reg, cy_reg;
    logic [30:0]        rad_reg;

    pipe_t            stg_reg  [NSTG];
    pipe_t            stg_next [NSTG];
    logic [NSTG-1:0]  vld_reg;
    logic [NSTG-1:0]  in_v;
    logic [NSTG:0]    rdy;
    out_t             out_reg, out_next;
    logic             out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            rad_reg <= 31'h7FFF_FFFF;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: cx_reg  <= cfg_wdata;
                CFG_CENTER_Y: cy_reg  <= cfg_wdata;
                CFG_RADIUS:   rad_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign rdy[NSTG] = !out_vld_reg || m_ready;
    assign s_ready   = rdy[0];

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        assign rdy[k]  = !vld_reg[k] || rdy[k+1];
        if (k == 0) begin : g_v0
            assign in_v[k] = s_valid;
        end else begin : g_vn
            assign in_v[k] = vld_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= in_v[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && in_v[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end

        if (k == ST_DIFF) begin : g_diff
            always_comb begin
                stg_next[k]    = '0;
                stg_next[k].dx = {s_data.point_x[31], s_data.point_x} - {cx_reg[31], cx_reg};
                stg_next[k].dy = {s_data.point_y[31], s_data.point_y} - {cy_reg[31], cy_reg};
                stg_next[k].z  = s_data.point_z;
            end
        end else if (k == ST_MAG) begin : g_mag
            always_comb begin
                stg_next[k]    = stg_reg[k-1];
                stg_next[k].sx = stg_reg[k-1].dx[32];
                stg_next[k].sy = stg_reg[k-1].dy[32];
                stg_next[k].ux = stg_reg[k-1].dx[32] ? 33'(-stg_reg[k-1].dx)
                                                     : 33'(stg_reg[k-1].dx);
                stg_next[k].uy = stg_reg[k-1].dy[32] ? 33'(-stg_reg[k-1].dy)
                                                     : 33'(stg_reg[k-1].dy);
            end
        end else if (k == ST_SQR) begin : g_sqr
            always_comb begin
                stg_next[k]     = stg_reg[k-1];
                stg_next[k].sqx = 66'(stg_reg[k-1].ux) * 66'(stg_reg[k-1].ux);
                stg_next[k].sqy = 66'(stg_reg[k-1].uy) * 66'(stg_reg[k-1].uy);
            end
        end else if (k == ST_SUM) begin : g_sum
            always_comb begin
                stg_next[k]      = stg_reg[k-1];
                stg_next[k].val  = stg_reg[k-1].sqx + stg_reg[k-1].sqy;
                stg_next[k].rem  = '0;
                stg_next[k].root = '0;
            end
        end else if (k < ST_MUL) begin : g_sqrt
            logic [35:0] remw, trial;
            always_comb begin
                stg_next[k]     = stg_reg[k-1];
                remw            = {stg_reg[k-1].rem[33:0], stg_reg[k-1].val[65:64]};
                trial           = {1'b0, stg_reg[k-1].root, 2'b01};
                stg_next[k].val = {stg_reg[k-1].val[63:0], 2'b00};
                if (remw >= trial) begin
                    stg_next[k].rem  = remw - trial;
                    stg_next[k].root = {stg_reg[k-1].root[31:0], 1'b1};
                end else begin
                    stg_next[k].rem  = remw;
                    stg_next[k].root = {stg_reg[k-1].root[31:0], 1'b0};
                end
            end
        end else if (k == ST_MUL) begin : g_mul
            always_comb begin
                stg_next[k]     = stg_reg[k-1];
                stg_next[k].prx = 64'(rad_reg) * 64'(stg_reg[k-1].ux);
                stg_next[k].pry = 64'(rad_reg) * 64'(stg_reg[k-1].uy);
            end
        end else if (k == ST_NUM) begin : g_num
            always_comb begin
                stg_next[k]      = stg_reg[k-1];
                // round half up: (2*r*u + d) / (2*d)
                stg_next[k].numx = {1'b0, stg_reg[k-1].prx, 1'b0} + 66'(stg_reg[k-1].root);
                stg_next[k].numy = {1'b0, stg_reg[k-1].pry, 1'b0} + 66'(stg_reg[k-1].root);
                stg_next[k].den  = {stg_reg[k-1].root, 1'b0};
                stg_next[k].qx   = '0;
                stg_next[k].qy   = '0;
            end
        end else begin : g_div
            localparam int J = NDIV - 1 - (k - ST_DV0);
            logic [65:0] sh;
            always_comb begin
                stg_next[k] = stg_reg[k-1];
                sh          = {32'b0, stg_reg[k-1].den} << J;
                if (stg_reg[k-1].numx >= sh) begin
                    stg_next[k].numx  = stg_reg[k-1].numx - sh;
                    stg_next[k].qx[J] = 1'b1;
                end
                if (stg_reg[k-1].numy >= sh) begin
                    stg_next[k].numy  = stg_reg[k-1].numy - sh;
                    stg_next[k].qy[J] = 1'b1;
                end
            end
        end
    end

    pipe_t              fin;
    logic               deg;
    logic signed [33:0] clr_w, offx, offy, nx_w, ny_w, rad_s, cx_s, cy_s;

    always_comb begin
        fin   = stg_reg[NSTG-1];
        deg   = (fin.root == '0);
        rad_s = $signed({3'b000, rad_reg});
        cx_s  = $signed({{2{cx_reg[31]}}, cx_reg});
        cy_s  = $signed({{2{cy_reg[31]}}, cy_reg});
        clr_w = rad_s - $signed({1'b0, fin.root});
        offx  = fin.sx ? -$signed({3'b000, fin.qx}) : $signed({3'b000, fin.qx});
        offy  = fin.sy ? -$signed({3'b000, fin.qy}) : $signed({3'b000, fin.qy});
        nx_w  = deg ? cx_s + rad_s : cx_s + offx;
        ny_w  = deg ? cy_s : cy_s + offy;
        out_next.inside_res = (fin.root < 33'(rad_reg));
        out_next.clearance  = sat32(clr_w);
        out_next.near_x     = sat32(nx_w);
        out_next.near_y     = sat32(ny_w);
        out_next.near_z     = fin.z;
        out_next.degenerate = deg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (rdy[NSTG]) begin
            out_vld_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NSTG] && vld_reg[NSTG-1]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    a_deg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.clearance == $signed({1'b0, rad_reg}))
        else $error("degenerate result with wrong clearance");

    a_inside_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.inside_res |-> m_data.clearance > 0)
        else $error("inside result with non-positive clearance");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[0] |-> s_ready)
        else $error("empty first stage refuses a request");

endmodule
`default_nettype wire

### bench/circle_boundary_clearance_tb.sv
// Testbench for circle_boundary_clearance: drives query points against several circles,
// predicts each result in 64/128-bit integer arithmetic and compares every field.
// Depends on cbc_pkg and the circle_boundary_clearance RTL.
`timescale 1ns / 100ps
module circle_boundary_clearance_tb;
    import cbc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    circle_boundary_clearance dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    logic signed [31:0] circ_cx, circ_cy;
    logic [30:0]        circ_r;
    out_t               pending_results[$];
    int                 n_errors;
    int                 n_sent;
    int                 n_checked;
    int                 send_idle_pct;
    int                 recv_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [33:0] floor_sqrt(input logic [127:0] v);
        logic [33:0]  root;
        logic [33:0]  trial;
        logic [127:0] sq;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            trial = root | (34'd1 << b);
            sq = 128'(trial) * 128'(trial);
            if (sq <= v) root = trial;
        end
        return root;
    endfunction

    function automatic logic signed [63:0] dir_offset(input logic [30:0] r,
            input logic signed [63:0] delta, input logic [63:0] d);
        logic [127:0] mag;
        logic [127:0] q;
        mag = delta < 0 ? 128'(-delta) : 128'(delta);
        q = (128'd2 * 128'(r) * mag + 128'(d)) / (128'd2 * 128'(d));
        return delta < 0 ? -$signed(64'(q)) : $signed(64'(q));
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic out_t predict_clearance(input in_t p);
        out_t               o;
        logic signed [63:0] dx, dy, nx, ny, rr, dd;
        logic [127:0]       sum;
        logic [63:0]        d;
        dx = 64'(p.point_x) - 64'(circ_cx);
        dy = 64'(p.point_y) - 64'(circ_cy);
        sum = 128'(dx < 0 ? -dx : dx) * 128'(dx < 0 ? -dx : dx)
            + 128'(dy < 0 ? -dy : dy) * 128'(dy < 0 ? -dy : dy);
        d = 64'(floor_sqrt(sum));
        rr = 64'(circ_r);
        dd = $signed(d);
        if (d == 0) begin
            nx = 64'(circ_cx) + rr;
            ny = 64'(circ_cy);
        end else begin
            nx = 64'(circ_cx) + dir_offset(circ_r, dx, d);
            ny = 64'(circ_cy) + dir_offset(circ_r, dy, d);
        end
        o.inside_res = dd < rr;
        o.clearance  = clamp32(rr - dd);
        o.near_x     = clamp32(nx);
        o.near_y     = clamp32(ny);
        o.near_z     = p.point_z;
        o.degenerate = d == 0;
        return o;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_CENTER_X: circ_cx = val;
            CFG_CENTER_Y: circ_cy = val;
            CFG_RADIUS:   circ_r  = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_circle(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] r);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RADIUS, r);
        cfg_we <= 1'b0;
    endtask

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        in_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        s_valid <= 1'b1;
        s_data  <= p;
        pending_results.push_back(predict_clearance(p));
        @(posedge aclk iff s_ready);
        n_sent++;
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (80) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            out_t e;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                e = pending_results.pop_front();
                n_checked++;
                if (m_data.inside_res !== e.inside_res) begin
                    $error("inside_res exp %0d got %0d", e.inside_res, m_data.inside_res);
                    n_errors++;
                end
                if (m_data.clearance !== e.clearance) begin
                    $error("clearance exp %0d got %0d", e.clearance, m_data.clearance);
                    n_errors++;
                end
                if (m_data.near_x !== e.near_x) begin
                    $error("near_x exp %0d got %0d", e.near_x, m_data.near_x);
                    n_errors++;
                end
                if (m_data.near_y !== e.near_y) begin
                    $error("near_y exp %0d got %0d", e.near_y, m_data.near_y);
                    n_errors++;
                end
                if (m_data.near_z !== e.near_z) begin
                    $error("near_z exp %0d got %0d", e.near_z, m_data.near_z);
                    n_errors++;
                end
                if (m_data.degenerate !== e.degenerate) begin
                    $error("degenerate exp %0d got %0d", e.degenerate, m_data.degenerate);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_reset_circle;
        send_point(32'h0, 32'h0, 32'h1234_5678);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_directed;
        set_circle(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h2);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h3);
        drain();
        set_circle(32'h0001_0000, 32'hFFFE_0000, 32'h0);
        send_point(32'h0001_0000, 32'hFFFE_0000, 32'h4);
        send_point(32'h0001_0001, 32'hFFFE_0000, 32'h5);
        send_point(32'h0, 32'h0, 32'h6);
        drain();
        set_circle(32'h0, 32'h0, 32'h0005_0000);
        send_point(32'h0003_0000, 32'h0004_0000, 32'h7);
        send_point(32'hFFFD_0000, 32'hFFFC_0000, 32'h8);
        send_point(32'h0002_0000, 32'h0, 32'h9);
        send_point(32'h0, 32'h0, 32'hA);
        send_point(32'h0000_0001, 32'h0000_0001, 32'hB);
        send_point(32'h0005_0000, 32'h0, 32'hC);
        drain();
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int count);
        logic [31:0] x, y;
        logic [30:0] r;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        r = $urandom_range(3) == 0 ? 31'h7FFF_FFFF : 31'($urandom_range(32'h00FF_FFFF));
        set_circle($urandom, $urandom, {1'b0, r});
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: begin x = $urandom; y = $urandom; end
                1: begin
                    x = circ_cx + 32'($signed(16'($urandom)));
                    y = circ_cy + 32'($signed(16'($urandom)));
                end
                2: begin
                    x = circ_cx + 32'($urandom_range(circ_r));
                    y = circ_cy - 32'($urandom_range(4));
                end
                default: begin x = circ_cx; y = circ_cy; end
            endcase
            send_point(x, y, $urandom);
        end
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        cfg_we  = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        circ_cx = '0;
        circ_cy = '0;
        circ_r  = 31'h7FFF_FFFF;
        n_errors = 0;
        n_sent = 0;
        n_checked = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_circle();
        test_directed();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: test_random_phase(0, 0, 125);
                1: test_random_phase(63, 0, 125);
                2: test_random_phase(0, 63, 125);
                default: test_random_phase(16, 16, 125);
            endcase
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            n_errors++;
        end
        $display("Sent %0d query points over 12 circle settings, %0d results checked.",
                 n_sent, n_checked);
        $display("Covered center hits, zero and full radius, extreme corners and stalls.");
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
